// ===== design/bmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared types, constants and helpers of the bitmask code decompressor.
// ----------------------------------------------------------------------------
package bmd_pkg;

    localparam int WORD_BITS        = 32;
    localparam int DICT_ENTRIES_DEF = 16;
    localparam int MAX_RESULTS      = 64;
    localparam int HEADER_BITS      = 3;
    localparam int BUF_BITS         = 2 * WORD_BITS;

    // command field of an input transaction
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_STREAM = 1'b1;

    typedef enum logic [2:0] {
        HDR_RAW       = 3'd0,
        HDR_REPEAT    = 3'd1,
        HDR_MASK      = 3'd2,
        HDR_FLIP1     = 3'd3,
        HDR_FLIP2     = 3'd4,
        HDR_FLIP4     = 3'd5,
        HDR_FLIP_PAIR = 3'd6,
        HDR_DIRECT    = 3'd7
    } bmd_hdr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_REPEAT,
        ST_FLUSH
    } bmd_state_t;

    typedef struct packed {
        logic load;      // write dictionary entry
        logic start;     // append stream word, begin decoding
        logic step;      // consume one code
        logic rep_emit;  // emit previous word once
        logic finish;    // push held word as last, close input
    } bmd_cmd_t;

    typedef struct packed {
        logic stop;        // not enough bits, or padding reached
        logic emits;       // current code yields a word
        logic rep_go;      // current code is a repeat with a valid previous word
        logic rep_last;    // last repeat emission
        logic can_emit;    // room to take one more word
        logic out_free;    // output register free this cycle
        logic held_valid;  // a word waits in the hold register
        logic ended;       // stream closed until reset
    } bmd_status_t;

    // body length after the header
    function automatic logic [5:0] body_bits(input bmd_hdr_t hdr);
        logic [5:0] n;
        unique case (hdr)
            HDR_RAW:       n = 6'd32;
            HDR_REPEAT:    n = 6'd3;
            HDR_MASK:      n = 6'd13;
            HDR_FLIP1:     n = 6'd9;
            HDR_FLIP2:     n = 6'd9;
            HDR_FLIP4:     n = 6'd9;
            HDR_FLIP_PAIR: n = 6'd14;
            HDR_DIRECT:    n = 6'd4;
            default:       n = 6'd0;
        endcase
        return n;
    endfunction

    // single-bit mask, position 0 is the MSB, positions past the word give zero
    function automatic logic [WORD_BITS-1:0] flip_bit(input logic [5:0] pos);
        logic [WORD_BITS-1:0] msb;
        msb = {1'b1, {(WORD_BITS-1){1'b0}}};
        if (pos < 6'(WORD_BITS)) begin
            return msb >> pos[4:0];
        end
        return '0;
    endfunction

endpackage

// ===== design/bmd_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_controller
// Sequencer: accepts transactions, steps the decoder one code per cycle unless
// the output stalls it, runs repeat emissions and closes each input.
// ----------------------------------------------------------------------------
module bmd_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,
    input  bmd_pkg::bmd_status_t status,
    output bmd_pkg::bmd_cmd_t    cmd
);
    import bmd_pkg::*;

    bmd_state_t state_reg;
    bmd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == CMD_LOAD) begin
                        cmd.load = 1'b1;
                    end else if (!status.ended) begin
                        cmd.start  = 1'b1;
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE:
            begin
                if (status.stop) begin
                    state_next = ST_FLUSH;
                end else if (!status.emits || status.can_emit) begin
                    cmd.step = 1'b1;
                    if (status.rep_go) begin
                        state_next = ST_REPEAT;
                    end
                end
            end
            ST_REPEAT:
            begin
                if (status.can_emit) begin
                    cmd.rep_emit = 1'b1;
                    if (status.rep_last) begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!status.held_valid || status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/bmd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_datapath
// Dictionary, bit buffer, code decoder, hold and output registers.
// ----------------------------------------------------------------------------
module bmd_datapath #(
    parameter int DICT_ENTRIES = bmd_pkg::DICT_ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bmd_pkg::bmd_cmd_t            cmd,
    output bmd_pkg::bmd_status_t         status,
    input  logic [3:0]                   in_index,
    input  logic [bmd_pkg::WORD_BITS-1:0] in_data,
    input  logic                         in_final,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [bmd_pkg::WORD_BITS-1:0] m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);
    import bmd_pkg::*;

    localparam int IDX_W = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;

    logic [WORD_BITS-1:0] dict_mem [DICT_ENTRIES];

    logic [BUF_BITS-1:0]  buf_reg;
    logic [6:0]           fill_reg;
    logic                 raw_pend_reg;
    logic                 final_reg;
    logic                 ended_reg;
    logic [WORD_BITS-1:0] prev_word_reg;
    logic                 prev_valid_reg;
    logic [3:0]           rep_cnt_reg;
    logic [6:0]           count_reg;
    logic [WORD_BITS-1:0] held_reg;
    logic                 held_valid_reg;
    logic [WORD_BITS-1:0] out_data_reg;
    logic                 out_last_reg;
    logic                 out_done_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] entry_reg;

    // decoder signals
    bmd_hdr_t             hdr;
    logic [5:0]           need;
    logic [5:0]           take;
    logic                 dec_stop;
    logic                 dec_emits;
    logic                 dec_raw_set;
    logic                 dec_raw_clr;
    logic                 dec_rep;
    logic [WORD_BITS-1:0] dec_word;
    logic [3:0]           rd_idx;
    logic [4:0]           pos_a;
    logic [4:0]           pos_b;
    logic [3:0]           mask;
    logic                 padded;

    logic                 emit_req;
    logic                 emit_keep;
    logic [WORD_BITS-1:0] emit_word;
    logic                 move_held;
    logic                 out_free;
    logic [BUF_BITS-1:0]  buf_append;
    logic [BUF_BITS-1:0]  buf_next;
    logic [6:0]           fill_next;
    bmd_hdr_t             next_hdr;

    // padding end: raw header pending, final word, remaining bits all zero
    assign padded = raw_pend_reg && final_reg && (fill_reg <= 7'(WORD_BITS))
                    && (buf_reg == '0);

    always_comb begin
        hdr         = bmd_hdr_t'(buf_reg[BUF_BITS-1 -: HEADER_BITS]);
        need        = 6'(HEADER_BITS) + body_bits(hdr);
        pos_a       = buf_reg[60:56];
        mask        = buf_reg[55:52];
        pos_b       = buf_reg[55:51];
        take        = '0;
        dec_stop    = 1'b0;
        dec_emits   = 1'b0;
        dec_raw_set = 1'b0;
        dec_raw_clr = 1'b0;
        dec_rep     = 1'b0;
        dec_word    = entry_reg;
        if (raw_pend_reg) begin
            if (padded || (fill_reg < 7'(WORD_BITS))) begin
                dec_stop = 1'b1;
            end else begin
                take        = 6'(WORD_BITS);
                dec_emits   = 1'b1;
                dec_raw_clr = 1'b1;
                dec_word    = buf_reg[BUF_BITS-1 -: WORD_BITS];
            end
        end else if (fill_reg < 7'(HEADER_BITS)) begin
            dec_stop = 1'b1;
        end else if (hdr == HDR_RAW) begin
            take        = 6'(HEADER_BITS);
            dec_raw_set = 1'b1;
        end else if (fill_reg < {1'b0, need}) begin
            dec_stop = 1'b1;
        end else begin
            take = need;
            unique case (hdr) inside
                HDR_REPEAT:
                begin
                    dec_rep = 1'b1;
                end
                HDR_MASK:
                begin
                    dec_emits = 1'b1;
                    dec_word  = entry_reg
                        ^ (mask[3] ? flip_bit({1'b0, pos_a}) : '0)
                        ^ (mask[2] ? flip_bit({1'b0, pos_a} + 6'd1) : '0)
                        ^ (mask[1] ? flip_bit({1'b0, pos_a} + 6'd2) : '0)
                        ^ (mask[0] ? flip_bit({1'b0, pos_a} + 6'd3) : '0);
                end
                HDR_FLIP1, HDR_FLIP2, HDR_FLIP4:
                begin
                    dec_emits = 1'b1;
                    dec_word  = entry_reg ^ flip_bit({1'b0, pos_a});
                    if (hdr != HDR_FLIP1) begin
                        dec_word = dec_word ^ flip_bit({1'b0, pos_a} + 6'd1);
                    end
                    if (hdr == HDR_FLIP4) begin
                        dec_word = dec_word ^ flip_bit({1'b0, pos_a} + 6'd2)
                                            ^ flip_bit({1'b0, pos_a} + 6'd3);
                    end
                end
                HDR_FLIP_PAIR:
                begin
                    dec_emits = 1'b1;
                    dec_word  = entry_reg ^ flip_bit({1'b0, pos_a})
                                          ^ flip_bit({1'b0, pos_b});
                end
                HDR_DIRECT:
                begin
                    dec_emits = 1'b1;
                end
                default:
                begin
                    dec_emits = 1'b0;
                end
            endcase
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign emit_req  = (cmd.step && dec_emits) || cmd.rep_emit;
    assign emit_word = cmd.rep_emit ? prev_word_reg : dec_word;
    assign emit_keep = emit_req && (count_reg < 7'(MAX_RESULTS));
    assign move_held = held_valid_reg && (emit_keep || cmd.finish);
    assign buf_append = {in_data, {WORD_BITS{1'b0}}} >> fill_reg;

    // next bit buffer contents
    always_comb begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        if (cmd.start && (fill_reg <= 7'(WORD_BITS))) begin
            buf_next  = buf_reg | buf_append;
            fill_next = fill_reg + 7'(WORD_BITS);
        end
        if (cmd.step) begin
            buf_next  = buf_reg << take;
            fill_next = fill_reg - {1'b0, take};
        end
        if (cmd.finish && final_reg) begin
            buf_next  = '0;
            fill_next = '0;
        end
    end

    // dictionary read address taken from the next buffer, so the entry is
    // registered by the time its code is decoded
    always_comb begin
        next_hdr = bmd_hdr_t'(buf_next[BUF_BITS-1 -: HEADER_BITS]);
        unique case (next_hdr) inside
            HDR_MASK:                        rd_idx = buf_next[51:48];
            HDR_FLIP1, HDR_FLIP2, HDR_FLIP4: rd_idx = buf_next[55:52];
            HDR_FLIP_PAIR:                   rd_idx = buf_next[50:47];
            default:                         rd_idx = buf_next[60:57];
        endcase
    end

    always_comb begin
        status            = '0;
        status.stop       = dec_stop;
        status.emits      = dec_emits;
        status.rep_go     = dec_rep && prev_valid_reg;
        status.rep_last   = (rep_cnt_reg == 4'd1);
        status.can_emit   = !held_valid_reg || out_free;
        status.out_free   = out_free;
        status.held_valid = held_valid_reg;
        status.ended      = ended_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            buf_reg        <= '0;
            fill_reg       <= '0;
            raw_pend_reg   <= 1'b0;
            final_reg      <= 1'b0;
            ended_reg      <= 1'b0;
            prev_word_reg  <= '0;
            prev_valid_reg <= 1'b0;
            rep_cnt_reg    <= '0;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            buf_reg  <= buf_next;
            fill_reg <= fill_next;
            if (cmd.start) begin
                final_reg <= in_final;
                count_reg <= '0;
            end
            if (cmd.step) begin
                if (dec_raw_set) begin
                    raw_pend_reg <= 1'b1;
                end
                if (dec_raw_clr) begin
                    raw_pend_reg <= 1'b0;
                end
                if (dec_emits) begin
                    prev_word_reg  <= dec_word;
                    prev_valid_reg <= 1'b1;
                end
                if (dec_rep) begin
                    rep_cnt_reg    <= {1'b0, buf_reg[60:58]} + 4'd1;
                    prev_valid_reg <= 1'b0;
                end
            end
            if (cmd.rep_emit) begin
                rep_cnt_reg <= rep_cnt_reg - 4'd1;
            end
            if (cmd.finish && final_reg) begin
                ended_reg    <= 1'b1;
                raw_pend_reg <= 1'b0;
            end
            if (emit_req && (count_reg < 7'(MAX_RESULTS))) begin
                count_reg <= count_reg + 7'd1;
            end
            if (emit_keep) begin
                held_valid_reg <= 1'b1;
            end else if (cmd.finish) begin
                held_valid_reg <= 1'b0;
            end
            if (move_held) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload; an index past the table reads as zero
    always_ff @(posedge clk) begin
        if (cmd.load && ({1'b0, in_index} < 5'(DICT_ENTRIES))) begin
            dict_mem[in_index[IDX_W-1:0]] <= in_data;
        end
        if ({1'b0, rd_idx} < 5'(DICT_ENTRIES)) begin
            entry_reg <= dict_mem[rd_idx[IDX_W-1:0]];
        end else begin
            entry_reg <= '0;
        end
        if (emit_keep) begin
            held_reg <= emit_word;
        end
        if (move_held) begin
            out_data_reg <= held_reg;
            out_last_reg <= cmd.finish;
            out_done_reg <= cmd.finish && padded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 7'(BUF_BITS))
        else $error("bit buffer fill out of range");

    a_start_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> fill_reg < 7'(WORD_BITS))
        else $error("stream word arrived with buffer too full");

    a_finish_drains: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !held_valid_reg)
        else $error("held word left after input closed");

    a_rep_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rep_emit |-> rep_cnt_reg != 4'd0)
        else $error("repeat emission with zero count");
`endif

endmodule

// ===== design/bitmask_code_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmask_code_decompressor
// Dictionary-based bitmask code decompressor: loads a word dictionary and
// expands a compressed bit stream into 32-bit instructions.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                              | tuser        | tlast
//  --------+-----+------------------------------------+--------------+-----------
//  s_*     | in  | [3:0] entry_index, [35:4] data_word| command      | final_word
//  m_*     | out | [31:0] instruction                 | stream_done  | run_last
//
//  Sequence: a dictionary load is written when accepted. A stream word is
//  accepted, then decoded one code per step (a raw word takes two steps:
//  header, literal), each repeated instruction is emitted in turn, the stop
//  is found and the input is closed; the dictionary entry of the next code
//  is registered at the edge that shifts the buffer.
//  Reset: asynchronous, clears buffer, fill, previous word and stream end;
//  the dictionary is not cleared and must be loaded before use.
//  Stalls: a full output register that is not taken, with a waiting held word,
//  halts word-emitting codes and repeats; s_tready is high only between input transactions.
//
module bitmask_code_decompressor #(
    parameter int DICT_ENTRIES = bmd_pkg::DICT_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] entry_index, [35:4] data_word, [39:36] zero
    input  logic        s_tuser,   // [0] command
    input  logic        s_tlast,   // final_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] instruction
    output logic        m_tuser,   // [0] stream_done
    output logic        m_tlast    // run_last
);
    import bmd_pkg::*;

    bmd_cmd_t    cmd;
    bmd_status_t status;

    // sequencer: one step per cycle unless the output stalls it, repeat and close phases
    bmd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // dictionary, bit buffer, decoder and output registers
    bmd_datapath #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_index (s_tdata[3:0]),
        .in_data  (s_tdata[35:4]),
        .in_final (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
